// ----- rtl/least_used_random_select_macros.svh -----
`ifndef LEAST_USED_RANDOM_SELECT_MACROS_SVH
`define LEAST_USED_RANDOM_SELECT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LURS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LURS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lurs_pkg.sv -----
package lurs_pkg;

	localparam int NUM_TABLES_DEF  = 16;
	localparam int MAX_ENTRIES_DEF = 32;

	localparam int COUNT_W = 8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic [3:0] table_id;
		logic [5:0] entry_count;
		logic [4:0] pick;
	} req_t;

	typedef struct packed {
		logic [4:0]         chosen_index;
		logic [COUNT_W-1:0] new_count;
		logic               pick_clamped;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MIN,
		ST_MIN_END,
		ST_SCAN,
		ST_SCAN_END,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/lurs_count_ram.sv -----
module lurs_count_ram #(
	parameter int DEPTH = lurs_pkg::NUM_TABLES_DEF * lurs_pkg::MAX_ENTRIES_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [lurs_pkg::COUNT_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic [lurs_pkg::COUNT_W-1:0] rd_data
);

	logic [lurs_pkg::COUNT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/least_used_random_select.sv -----
// Channel  Dir  Payload          Handshake
// req      in   lurs_pkg::req_t  req_valid / req_stall
// rsp      out  lurs_pkg::rsp_t  rsp_valid / rsp_stall
//
// One request at a time: a request to a valid table takes two read passes over
// its row in the single count RAM, one read a cycle, plus the write-back.
// After reset a clearing pass zeroes the RAM, one entry a cycle; req_stall
// stays high meanwhile.
// A result waiting in the output register does not block the next request;
// only its result and write-back wait until the output register frees up.
module least_used_random_select #(
	parameter int NUM_TABLES  = lurs_pkg::NUM_TABLES_DEF,
	parameter int MAX_ENTRIES = lurs_pkg::MAX_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lurs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lurs_pkg::rsp_t rsp
);

	localparam int DEPTH = NUM_TABLES * MAX_ENTRIES;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_ENTRIES);
	localparam int CW    = $clog2(MAX_ENTRIES + 1);

	lurs_pkg::state_t state_q, state_d;

	logic [AW-1:0]                clr_addr_q;
	logic [AW-1:0]                base_q;
	logic [IW-1:0]                last_q;
	logic [4:0]                   pick_q;
	logic                         hit_q;
	logic [IW-1:0]                idx_q;
	logic                         rv_s1;
	logic [IW-1:0]                ridx_s1;
	logic [lurs_pkg::COUNT_W-1:0] rdata_s1;
	logic [lurs_pkg::COUNT_W-1:0] min_q;
	logic [CW-1:0]                seen_q;
	logic                         found_q;
	logic [IW-1:0]                chosen_q;
	logic [IW-1:0]                lastc_q;
	lurs_pkg::rsp_t               rsp_q;
	logic                         rsp_valid_q;

	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [lurs_pkg::COUNT_W-1:0] wr_data;
	logic                         load_rsp;
	logic                         req_acc;
	logic [31:0]                  req_n;
	logic                         req_hit;
	logic [IW-1:0]                sel_idx;
	logic [lurs_pkg::COUNT_W-1:0] inc_count;
	logic                         pass1;
	logic                         pass2;

	// clamp the entry count to 1..MAX_ENTRIES
	always_comb begin
		req_n = 32'(req.entry_count);
		if (req_n == 32'd0) begin
			req_n = 32'd1;
		end
		if (req_n > 32'(MAX_ENTRIES)) begin
			req_n = 32'(MAX_ENTRIES);
		end
	end

	assign req_hit   = 32'(req.table_id) < 32'(NUM_TABLES);
	assign req_acc   = req_valid && !req_stall;
	assign sel_idx   = found_q ? chosen_q : lastc_q;
	assign inc_count = (min_q == lurs_pkg::COUNT_MAX) ? lurs_pkg::COUNT_MAX
	                                                  : min_q + 8'd1;
	assign rd_addr   = base_q + AW'(idx_q);
	assign pass1     = rv_s1 && (state_q == lurs_pkg::ST_MIN || state_q == lurs_pkg::ST_MIN_END);
	assign pass2     = rv_s1 && (state_q == lurs_pkg::ST_SCAN || state_q == lurs_pkg::ST_SCAN_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lurs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = clr_addr_q;
		wr_data   = '0;
		load_rsp  = 1'b0;
		unique case (state_q)
			lurs_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = lurs_pkg::ST_IDLE;
				end
			end
			lurs_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = req_hit ? lurs_pkg::ST_MIN : lurs_pkg::ST_DONE;
				end
			end
			lurs_pkg::ST_MIN: begin
				rd_en = 1'b1;
				if (idx_q == last_q) begin
					state_d = lurs_pkg::ST_MIN_END;
				end
			end
			lurs_pkg::ST_MIN_END: begin
				state_d = lurs_pkg::ST_SCAN;
			end
			lurs_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (idx_q == last_q) begin
					state_d = lurs_pkg::ST_SCAN_END;
				end
			end
			lurs_pkg::ST_SCAN_END: begin
				state_d = lurs_pkg::ST_DONE;
			end
			lurs_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					wr_en    = hit_q;
					wr_addr  = base_q + AW'(sel_idx);
					wr_data  = inc_count;
					state_d  = lurs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lurs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			rv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (state_q == lurs_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			rv_s1 <= rd_en;
			if (req_acc) begin
				found_q <= 1'b0;
			end else if (pass2 && rdata_s1 == min_q && !found_q
			             && 32'(seen_q) == 32'(pick_q)) begin
				found_q <= 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= idx_q;
		if (req_acc) begin
			base_q  <= AW'(32'(req.table_id) * 32'(MAX_ENTRIES));
			last_q  <= IW'(req_n - 32'd1);
			pick_q  <= req.pick;
			hit_q   <= req_hit;
			idx_q   <= '0;
			min_q   <= lurs_pkg::COUNT_MAX;
			seen_q  <= '0;
			chosen_q <= '0;
			lastc_q <= '0;
		end
		if (state_q == lurs_pkg::ST_MIN || state_q == lurs_pkg::ST_SCAN) begin
			idx_q <= idx_q + IW'(1);
		end else if (state_q == lurs_pkg::ST_MIN_END) begin
			idx_q <= '0;
		end
		if (pass1 && rdata_s1 < min_q) begin
			min_q <= rdata_s1;
		end
		// second pass: remember the pick-th candidate and the last one seen
		if (pass2 && rdata_s1 == min_q) begin
			lastc_q <= ridx_s1;
			if (!found_q) begin
				if (32'(seen_q) == 32'(pick_q)) begin
					chosen_q <= ridx_s1;
				end else begin
					seen_q <= seen_q + CW'(1);
				end
			end
		end
		if (load_rsp) begin
			rsp_q.chosen_index <= hit_q ? 5'(sel_idx) : 5'd0;
			rsp_q.new_count    <= hit_q ? inc_count : '0;
			rsp_q.pick_clamped <= hit_q && !found_q;
		end
	end

	lurs_count_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rdata_s1)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/lurs_checker.sv -----
`include "least_used_random_select_macros.svh"

module lurs_checker #(
	parameter int NUM_TABLES = lurs_pkg::NUM_TABLES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input lurs_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input lurs_pkg::rsp_t rsp
);

	logic       req_acc;
	logic       rsp_acc;
	logic [1:0] pending_q;
	logic [4:0] last_pick_q;
	logic       last_hit_q;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	// beats accepted on req but not yet delivered on rsp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			last_pick_q <= '0;
			last_hit_q  <= 1'b0;
		end else begin
			pending_q <= pending_q + 2'(req_acc) - 2'(rsp_acc);
			if (req_acc) begin
				last_pick_q <= req.pick;
				last_hit_q  <= 32'(req.table_id) < 32'(NUM_TABLES);
			end
		end
	end

	`LURS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp beat changed while stalled")
	`LURS_ASSERT_NOW(a_no_extra_rsp, rsp_acc, pending_q != 2'd0, "rsp beat without a pending request")
	`LURS_ASSERT_NOW(a_pick0_unclamped, $rose(rsp_valid) && last_pick_q == 5'd0, !rsp.pick_clamped, "pick of zero reported as clamped")
	`LURS_ASSERT_NOW(a_count_nonzero, $rose(rsp_valid) && last_hit_q, rsp.new_count != 8'd0, "selected entry count not incremented")

endmodule

bind least_used_random_select lurs_checker #(.NUM_TABLES(NUM_TABLES)) u_lurs_checker (.*);
